>>> rtl/ept_pkg.sv
// Shared types, constants and the EGA palette for the planar-to-texel converter.
// No dependencies; used by ept_front, ept_queue, ept_back and the top level.
package ept_pkg;

  localparam int MAX_SIDE_DEF = 512;

  localparam int POS_W       = 15;
  localparam int PLANE_W     = 8;
  localparam int MODE_W      = 2;
  localparam int IW_W        = 10;
  localparam int QUO_W       = 18;
  localparam int ROW_W       = 28;
  localparam int ADDR_FULL_W = 29;
  localparam int ADDR_W      = 18;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int TEXEL_CNT_W = 3;

  // Divider retires this many quotient bits per cycle.
  localparam int DIV_STEPS  = 3;
  localparam int DIV_CYCLES = QUO_W / DIV_STEPS;
  localparam int DIV_CNT_W  = 3;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WIDTH = 2'd2;

  localparam logic [MODE_W-1:0] MODE_OPAQUE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_KEYED  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MASKED = 2'd2;

  localparam logic [MODE_W-1:0] RESET_PLANE_MODE    = MODE_OPAQUE;
  localparam logic [IW_W-1:0]   RESET_IMAGE_WIDTH   = 10'd8;
  localparam logic [IW_W-1:0]   RESET_TEXTURE_WIDTH = 10'd8;

  localparam logic [3:0] KEY_COLOR   = 4'd5;
  localparam logic [7:0] ALPHA_SOLID = 8'hFF;

  typedef struct packed {
    logic [PLANE_W-1:0] mask;
    logic [PLANE_W-1:0] blue;
    logic [PLANE_W-1:0] green;
    logic [PLANE_W-1:0] red;
    logic [PLANE_W-1:0] intensity;
  } planes_t;

  // Configuration as seen by the datapath; img_w already has zero mapped to one.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IW_W-1:0]   img_w;
    logic [IW_W-1:0]   tex_w;
  } cfg_t;

  // One queued byte: start column, start row base (y * pitch), plane bytes.
  typedef struct packed {
    logic [IW_W-1:0]  x;
    logic [ROW_W-1:0] row;
    planes_t          planes;
  } work_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV,
    FE_MUL
  } fe_state_t;

  // Standard 16-color EGA palette, {red, green, blue}.
  function automatic logic [23:0] ega_palette(input logic [3:0] idx);
    logic [23:0] rgb;
    begin
      case (idx)
        4'd0:    rgb = 24'h000000;
        4'd1:    rgb = 24'h0000AA;
        4'd2:    rgb = 24'h00AA00;
        4'd3:    rgb = 24'h00AAAA;
        4'd4:    rgb = 24'hAA0000;
        4'd5:    rgb = 24'hAA00AA;
        4'd6:    rgb = 24'hAA5500;
        4'd7:    rgb = 24'hAAAAAA;
        4'd8:    rgb = 24'h555555;
        4'd9:    rgb = 24'h5555FF;
        4'd10:   rgb = 24'h55FF55;
        4'd11:   rgb = 24'h55FFFF;
        4'd12:   rgb = 24'hFF5555;
        4'd13:   rgb = 24'hFF55FF;
        4'd14:   rgb = 24'hFFFF55;
        4'd15:   rgb = 24'hFFFFFF;
        default: rgb = 24'h000000;
      endcase
      return rgb;
    end
  endfunction

endpackage

>>> rtl/ept_front.sv
// Front end: takes a byte, divides its first pixel offset by the image width
// and forms the row base. Depends on ept_pkg.
module ept_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [14:0]       byte_position,
  input  ept_pkg::planes_t  planes_in,
  input  ept_pkg::cfg_t     cfg,
  input  logic              q_full,
  output logic              q_push,
  output ept_pkg::work_t    q_data
);
  import ept_pkg::*;

  fe_state_t             state, state_next;
  logic [QUO_W-1:0]      dvd;
  logic [QUO_W-1:0]      quo;
  logic [IW_W-1:0]       rem;
  logic [DIV_CNT_W-1:0]  div_cnt;
  planes_t               planes;

  logic [QUO_W-1:0]      dvd_next;
  logic [QUO_W-1:0]      quo_next;
  logic [IW_W-1:0]       rem_next;
  logic                  accept;
  logic                  div_done;
  logic [ROW_W-1:0]      row_prod;

  // Restoring division, DIV_STEPS quotient bits per cycle.
  always_comb begin
    logic [IW_W:0] t;
    dvd_next = dvd;
    quo_next = quo;
    rem_next = rem;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t        = {rem_next, dvd_next[QUO_W-1]};
      dvd_next = {dvd_next[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, cfg.img_w}) begin
        rem_next = IW_W'(t - {1'b0, cfg.img_w});
        quo_next = {quo_next[QUO_W-2:0], 1'b1};
      end else begin
        rem_next = t[IW_W-1:0];
        quo_next = {quo_next[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign div_done = (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1));
  assign row_prod = ROW_W'(quo) * ROW_W'(cfg.tex_w);

  assign q_data.x      = rem;
  assign q_data.row    = row_prod;
  assign q_data.planes = planes;

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    q_push     = 1'b0;
    case (state)
      FE_IDLE: begin
        if (start) begin
          state_next = FE_DIV;
        end
      end
      FE_DIV: begin
        busy = 1'b1;
        if (div_done) begin
          state_next = FE_MUL;
        end
      end
      FE_MUL: begin
        busy = q_full;
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = start ? FE_DIV : FE_IDLE;
        end
      end
      default: begin
        state_next = FE_IDLE;
      end
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dvd     <= {byte_position, 3'b000};
      quo     <= '0;
      rem     <= '0;
      div_cnt <= '0;
      planes  <= planes_in;
    end else if (state == FE_DIV) begin
      dvd     <= dvd_next;
      quo     <= quo_next;
      rem     <= rem_next;
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

endmodule

>>> rtl/ept_queue.sv
// Two-entry queue between front and back ends.
// Depends on ept_pkg for the entry type.
module ept_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ept_pkg::work_t  din,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output ept_pkg::work_t  dout
);
  import ept_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

>>> rtl/ept_back.sv
// Back end: walks eight texels of a queued byte, one per cycle, with palette,
// keying or masking and address stepping. Depends on ept_pkg.
module ept_back #(
  parameter int MAX_TEXTURE_SIDE = ept_pkg::MAX_SIDE_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  ept_pkg::cfg_t   cfg,
  input  logic            q_empty,
  input  ept_pkg::work_t  q_data,
  output logic            q_pop,
  output logic            texel_valid,
  output logic [17:0]     texel_address,
  output logic [7:0]      red_out,
  output logic [7:0]      green_out,
  output logic [7:0]      blue_out,
  output logic [7:0]      alpha_out,
  output logic            outside_texture,
  output logic            last_of_byte
);
  import ept_pkg::*;

  localparam logic [ADDR_FULL_W-1:0] LIMIT =
    ADDR_FULL_W'(MAX_TEXTURE_SIDE * MAX_TEXTURE_SIDE);

  logic                    active;
  logic [TEXEL_CNT_W-1:0]  k;
  logic [IW_W-1:0]         x;
  logic [ROW_W-1:0]        row;
  planes_t                 planes;

  logic                    last_k;
  logic [TEXEL_CNT_W-1:0]  bit_sel;
  logic [3:0]              idx;
  logic                    clear;
  logic [23:0]             rgb;
  logic [ADDR_FULL_W-1:0]  addr_full;
  logic                    wrap;

  assign last_k  = (k == '1);
  assign q_pop   = !q_empty && (!active || last_k);
  assign bit_sel = ~k;  // texel k uses plane bit 7 - k
  assign idx     = {planes.intensity[bit_sel], planes.red[bit_sel],
                    planes.green[bit_sel], planes.blue[bit_sel]};
  assign rgb     = ega_palette(idx);
  assign addr_full = ADDR_FULL_W'(row) + ADDR_FULL_W'(x);
  assign wrap    = (x == cfg.img_w - IW_W'(1));

  always_comb begin
    case (cfg.mode)
      MODE_KEYED:  clear = (idx == KEY_COLOR);
      MODE_MASKED: clear = planes.mask[bit_sel];
      default:     clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      texel_valid <= 1'b0;
    end else begin
      texel_valid <= active;
      if (q_pop) begin
        active <= 1'b1;
      end else if (last_k) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      k      <= '0;
      x      <= q_data.x;
      row    <= q_data.row;
      planes <= q_data.planes;
    end else if (active) begin
      k <= k + TEXEL_CNT_W'(1);
      if (wrap) begin
        x   <= '0;
        row <= row + ROW_W'(cfg.tex_w);
      end else begin
        x <= x + IW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      texel_address   <= addr_full[ADDR_W-1:0];
      red_out         <= clear ? 8'h00 : rgb[23:16];
      green_out       <= clear ? 8'h00 : rgb[15:8];
      blue_out        <= clear ? 8'h00 : rgb[7:0];
      alpha_out       <= clear ? 8'h00 : ALPHA_SOLID;
      outside_texture <= (addr_full >= LIMIT);
      last_of_byte    <= last_k;
    end
  end

endmodule

>>> rtl/ega_planar_to_rgba_texels.sv
// Path: divider (FE_DIV), row multiply and push (FE_MUL), queue, back-end registers,
// registered outputs. Texels leave one per cycle, a byte's eight back to back; the
// divider (3 quotient bits a cycle) accepts again as it pushes, if the queue has room.
// Reset (rst, synchronous): queue emptied, no texel in flight, registers to
// plane_mode 0, image_width 8, texture_width 8. The receiver cannot stall.
module ega_planar_to_rgba_texels #(
  parameter int MAX_TEXTURE_SIDE = ept_pkg::MAX_SIDE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // command channel
  input  logic         start,
  output logic         busy,
  input  logic [14:0]  byte_position,
  input  logic [7:0]   mask_bits,
  input  logic [7:0]   blue_bits,
  input  logic [7:0]   green_bits,
  input  logic [7:0]   red_bits,
  input  logic [7:0]   intensity_bits,
  // configuration writes
  input  logic         cfg_write,
  input  logic [1:0]   cfg_index,
  input  logic [9:0]   cfg_data,
  // texel results, one transfer per strobe
  output logic         texel_valid,
  output logic [17:0]  texel_address,
  output logic [7:0]   red_out,
  output logic [7:0]   green_out,
  output logic [7:0]   blue_out,
  output logic [7:0]   alpha_out,
  output logic         outside_texture,
  output logic         last_of_byte
);
  import ept_pkg::*;

  logic [MODE_W-1:0] plane_mode;
  logic [IW_W-1:0]   image_width;
  logic [IW_W-1:0]   texture_width;
  cfg_t              cfg;
  planes_t           planes_in;

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  work_t             q_in;
  work_t             q_out;

  // Config registers; index 3 is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_mode    <= RESET_PLANE_MODE;
      image_width   <= RESET_IMAGE_WIDTH;
      texture_width <= RESET_TEXTURE_WIDTH;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PLANE_MODE:    plane_mode    <= cfg_data[MODE_W-1:0];
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[IW_W-1:0];
        REG_TEXTURE_WIDTH: texture_width <= cfg_data[IW_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero image width divides as one.
  assign cfg.mode  = plane_mode;
  assign cfg.img_w = (image_width == '0) ? IW_W'(1) : image_width;
  assign cfg.tex_w = texture_width;

  assign planes_in.mask      = mask_bits;
  assign planes_in.blue      = blue_bits;
  assign planes_in.green     = green_bits;
  assign planes_in.red       = red_bits;
  assign planes_in.intensity = intensity_bits;

  // Front: offset / image_width -> (x, y), then y * texture_width.
  ept_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .byte_position (byte_position),
    .planes_in     (planes_in),
    .cfg           (cfg),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (q_in)
  );

  // Decouples the divider from texel output.
  ept_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_out)
  );

  // Back: eight texels per byte, x/row stepped incrementally.
  ept_back #(
    .MAX_TEXTURE_SIDE (MAX_TEXTURE_SIDE)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_empty         (q_empty),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .texel_valid     (texel_valid),
    .texel_address   (texel_address),
    .red_out         (red_out),
    .green_out       (green_out),
    .blue_out        (blue_out),
    .alpha_out       (alpha_out),
    .outside_texture (outside_texture),
    .last_of_byte    (last_of_byte)
  );

endmodule

>>> rtl/ept_checker.sv
// Port-level checks for ega_planar_to_rgba_texels, attached by bind.
// Depends only on the top level's ports.
module ept_checker (
  input logic        clk,
  input logic        rst,
  input logic        texel_valid,
  input logic [7:0]  red_out,
  input logic [7:0]  green_out,
  input logic [7:0]  blue_out,
  input logic [7:0]  alpha_out,
  input logic        last_of_byte
);

  // Reset kills any burst in flight.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !texel_valid)
    else $error("texel strobe right after reset");

  // Texels of one byte come in an unbroken run up to last_of_byte.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    texel_valid && !last_of_byte |=> texel_valid)
    else $error("texel run broken before last texel");

  // Alpha is all or nothing.
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    texel_valid |-> (alpha_out == 8'h00 || alpha_out == 8'hFF))
    else $error("alpha neither clear nor solid");

  // Transparent texels are black.
  a_clear_black: assert property (@(posedge clk) disable iff (rst)
    texel_valid && alpha_out == 8'h00 |->
      red_out == 8'h00 && green_out == 8'h00 && blue_out == 8'h00)
    else $error("transparent texel carries color");

endmodule

bind ega_planar_to_rgba_texels ept_checker u_ept_checker (
  .clk          (clk),
  .rst          (rst),
  .texel_valid  (texel_valid),
  .red_out      (red_out),
  .green_out    (green_out),
  .blue_out     (blue_out),
  .alpha_out    (alpha_out),
  .last_of_byte (last_of_byte)
);
